// ===== src/tsp_pkg.sv =====
// Shared constants, request codes and the result type of the travelling-salesman search block.
package tsp_pkg;

  // Default sizing of the search engine and the cost store.
  localparam int MAX_CITIES_DEF = 16;
  localparam int COST_WIDTH_DEF = 16;

  // Fixed widths of the channel fields and the configuration register.
  localparam int CITY_W   = 4;
  localparam int COST_IN_W = 16;
  localparam int BEST_W   = 20;
  localparam int CCOUNT_W = 5;

  // Configuration port geometry.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register index codes, taken from the word address bit of paddr.
  localparam logic REG_CITY_COUNT = 1'b0;

  // Reset value of the city count register.
  localparam logic [CCOUNT_W-1:0] CITY_COUNT_RST = 5'd16;

  // Request codes of an input item.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  // Result of one search run.
  typedef struct packed {
    logic [BEST_W-1:0] best_cost;
    logic              no_tour;
  } tsp_res_t;

endpackage

// ===== src/tsp_if.sv =====
// Valid/ready channel interfaces for the request and result streams.
interface tsp_in_if;
  import tsp_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [CITY_W-1:0]    from_city;
  logic [CITY_W-1:0]    to_city;
  logic [COST_IN_W-1:0] edge_cost;

  modport source (output valid, output req_type, output from_city, output to_city,
                  output edge_cost, input ready);
  modport sink   (input valid, input req_type, input from_city, input to_city,
                  input edge_cost, output ready);
endinterface

interface tsp_out_if;
  import tsp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BEST_W-1:0] best_cost;
  logic              no_tour;

  modport source (output valid, output best_cost, output no_tour, input ready);
  modport sink   (input valid, input best_cost, input no_tour, output ready);
endinterface

// ===== src/tsp_exhaustive_search.sv =====
// Top level of the exhaustive travelling-salesman search block.
//
// Requests arrive on in_ch. A load request writes one cost-matrix entry and
// gives no result; loads are taken back to back whenever the search engine is
// idle. A run request starts a depth-first backtracking search over all tours
// that leave and return to city zero, and gives one result on out_ch: the least
// tour cost, or no_tour with a zero cost when fewer than two cities are
// configured. The city count is written over the APB-style port. A run steps
// through candidate edges, candidates already on the path, backtracks and
// closed tours, bounded by the order of (n-1)! tours for n cities; the single
// cost-matrix read port and the one shared adder set this pace. Branches that
// cannot beat the best tour are cut early, so typical runs are much shorter.
// While a run is busy, in_ch.ready stays low. The result waits in an output
// register: a stalled receiver does not block further loads or the search of
// the next run, but that run's result then waits in the engine and in_ch.ready
// stays low until the receiver takes the first. Reset returns the engine to
// idle and the city count to sixteen; the cost matrix is not cleared and must
// be loaded before a run reads it.
module tsp_exhaustive_search #(
  parameter int MAX_CITIES = tsp_pkg::MAX_CITIES_DEF,
  parameter int COST_WIDTH = tsp_pkg::COST_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tsp_in_if.sink                      in_ch,
  tsp_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsp_pkg::APB_AW-1:0]  paddr,
  input  logic [tsp_pkg::APB_DW-1:0]  pwdata,
  output logic [tsp_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import tsp_pkg::*;

  localparam int IW = $clog2(MAX_CITIES);

  logic                  in_xfer;
  logic                  load_en;
  logic                  start;
  logic [CCOUNT_W-1:0]   city_count;
  logic                  eng_idle;
  logic                  rd_en;
  logic [IW-1:0]         rd_row;
  logic [IW-1:0]         rd_col;
  logic [COST_WIDTH-1:0] rd_data;
  logic                  res_valid;
  logic                  res_take;
  tsp_res_t              res;
  logic                  out_valid_r, out_valid_nxt;
  tsp_res_t              out_res_r;

  // Configuration registers.
  tsp_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .city_count (city_count)
  );

  // Request decode; loads outside the matrix are dropped.
  assign in_ch.ready = eng_idle;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign load_en     = in_xfer && (in_ch.req_type == REQ_LOAD)
                       && (int'(in_ch.from_city) < MAX_CITIES)
                       && (int'(in_ch.to_city) < MAX_CITIES);
  assign start       = in_xfer && (in_ch.req_type == REQ_RUN);

  tsp_cost_mem #(
    .MAX_CITIES (MAX_CITIES),
    .COST_WIDTH (COST_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_row  (IW'(in_ch.from_city)),
    .wr_col  (IW'(in_ch.to_city)),
    .wr_data (COST_WIDTH'(in_ch.edge_cost)),
    .rd_en   (rd_en),
    .rd_row  (rd_row),
    .rd_col  (rd_col),
    .rd_data (rd_data)
  );

  tsp_search #(
    .MAX_CITIES (MAX_CITIES),
    .COST_WIDTH (COST_WIDTH)
  ) u_search (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .city_count (city_count),
    .idle       (eng_idle),
    .rd_en      (rd_en),
    .rd_row     (rd_row),
    .rd_col     (rd_col),
    .rd_data    (rd_data),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res)
  );

  // Output register: takes a finished result whenever the slot is free or drains.
  assign res_take = res_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.best_cost = out_res_r.best_cost;
  assign out_ch.no_tour   = out_res_r.no_tour;

endmodule

// ===== src/tsp_cfg.sv =====
// APB-style register file holding the city count.
module tsp_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tsp_pkg::APB_AW-1:0]    paddr,
  input  logic [tsp_pkg::APB_DW-1:0]    pwdata,
  output logic [tsp_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  output logic [tsp_pkg::CCOUNT_W-1:0]  city_count
);
  import tsp_pkg::*;

  logic [CCOUNT_W-1:0] city_count_r;
  logic [CCOUNT_W-1:0] city_count_nxt;
  logic                wr_en;

  // A write lands in the access phase; other word addresses are ignored.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_CITY_COUNT);

  always_comb begin
    city_count_nxt = city_count_r;
    if (wr_en) begin
      city_count_nxt = pwdata[CCOUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      city_count_r <= CITY_COUNT_RST;
    end else begin
      city_count_r <= city_count_nxt;
    end
  end

  // Read back the register, zero for unmapped addresses.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_CITY_COUNT) begin
      prdata = APB_DW'(city_count_r);
    end
  end

  assign city_count = city_count_r;

endmodule

// ===== src/tsp_cost_mem.sv =====
// Cost matrix store: one write port for loads and one registered read port for the search.
module tsp_cost_mem #(
  parameter int MAX_CITIES = tsp_pkg::MAX_CITIES_DEF,
  parameter int COST_WIDTH = tsp_pkg::COST_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_CITIES)-1:0] wr_row,
  input  logic [$clog2(MAX_CITIES)-1:0] wr_col,
  input  logic [COST_WIDTH-1:0]         wr_data,
  input  logic                          rd_en,
  input  logic [$clog2(MAX_CITIES)-1:0] rd_row,
  input  logic [$clog2(MAX_CITIES)-1:0] rd_col,
  output logic [COST_WIDTH-1:0]         rd_data
);
  import tsp_pkg::*;

  logic [COST_WIDTH-1:0] cost_ram [MAX_CITIES][MAX_CITIES];
  logic [COST_WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cost_ram[wr_row][wr_col] <= wr_data;
    end
  end

  // Registered read port; data is valid the cycle after the request.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= cost_ram[rd_row][rd_col];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/tsp_search.sv =====
// Depth-first backtracking sequencer with one shared adder for the tour search.
module tsp_search #(
  parameter int MAX_CITIES = tsp_pkg::MAX_CITIES_DEF,
  parameter int COST_WIDTH = tsp_pkg::COST_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [tsp_pkg::CCOUNT_W-1:0]  city_count,
  output logic                          idle,
  output logic                          rd_en,
  output logic [$clog2(MAX_CITIES)-1:0] rd_row,
  output logic [$clog2(MAX_CITIES)-1:0] rd_col,
  input  logic [COST_WIDTH-1:0]         rd_data,
  output logic                          res_valid,
  input  logic                          res_take,
  output tsp_pkg::tsp_res_t             res
);
  import tsp_pkg::*;

  localparam int IW = $clog2(MAX_CITIES);
  localparam int CW = $clog2(MAX_CITIES + 1);
  localparam int SW = COST_WIDTH + $clog2(MAX_CITIES);
  localparam int BW = SW + 1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_EVAL  = 5'b00100,
    ST_CLOSE = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [IW-1:0]         depth_r, depth_nxt;
  logic [CW-1:0]         n_r, n_nxt;
  logic [BW-1:0]         best_r, best_nxt;
  logic [SW-1:0]         hold_r, hold_nxt;
  logic [IW-1:0]         city_r, city_nxt;
  logic                  no_tour_r, no_tour_nxt;
  logic [MAX_CITIES-1:0] visited_r, visited_nxt;

  // Per-level stacks: candidate pointer, city on the path and cost up to that city.
  logic [CW-1:0] cand_r [MAX_CITIES];
  logic [IW-1:0] path_r [MAX_CITIES];
  logic [SW-1:0] cost_r [MAX_CITIES];

  logic          cand_we;
  logic [IW-1:0] cand_idx;
  logic [CW-1:0] cand_val;
  logic          push_we;
  logic [IW-1:0] push_idx;
  logic [IW-1:0] push_city;
  logic [SW-1:0] push_cost;

  logic [IW-1:0] top_idx;
  logic [CW-1:0] cur_cand;
  logic [IW-1:0] cand_city;
  logic [IW-1:0] prev_city;
  logic [SW-1:0] base_cost;
  logic [SW-1:0] add_a;
  logic [SW-1:0] sum;
  logic          last_level;
  logic [CW-1:0] n_sat;

  // Views of the top of the stack.
  assign top_idx   = depth_r - 1'b1;
  assign cur_cand  = cand_r[depth_r];
  assign cand_city = cur_cand[IW-1:0];
  assign prev_city = path_r[top_idx];
  assign base_cost = cost_r[top_idx];

  // The shared adder: extends a partial path, or closes a tour back to city zero.
  assign add_a      = (state_r == ST_CLOSE) ? hold_r : base_cost;
  assign sum        = add_a + SW'(rd_data);
  assign last_level = (CW'(depth_r) == (n_r - 1'b1));

  // City counts beyond the supported maximum are clamped.
  always_comb begin
    if (int'(city_count) > MAX_CITIES) begin
      n_sat = CW'(MAX_CITIES);
    end else begin
      n_sat = CW'(city_count);
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt   = state_r;
    depth_nxt   = depth_r;
    n_nxt       = n_r;
    best_nxt    = best_r;
    hold_nxt    = hold_r;
    city_nxt    = city_r;
    no_tour_nxt = no_tour_r;
    visited_nxt = visited_r;
    cand_we     = 1'b0;
    cand_idx    = depth_r;
    cand_val    = cur_cand + 1'b1;
    push_we     = 1'b0;
    push_idx    = depth_r;
    push_city   = city_r;
    push_cost   = sum;
    rd_en       = 1'b0;
    rd_row      = prev_city;
    rd_col      = cand_city;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          n_nxt       = n_sat;
          best_nxt    = '1;
          visited_nxt = '0;
          if (n_sat < CW'(2)) begin
            no_tour_nxt = 1'b1;
            state_nxt   = ST_DONE;
          end else begin
            // City zero sits at level zero; level one starts at city one.
            no_tour_nxt = 1'b0;
            depth_nxt   = IW'(1);
            cand_we     = 1'b1;
            cand_idx    = IW'(1);
            cand_val    = CW'(1);
            push_we     = 1'b1;
            push_idx    = '0;
            push_city   = '0;
            push_cost   = '0;
            state_nxt   = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (cur_cand >= n_r) begin
          // Candidates exhausted at this level: backtrack or finish.
          if (depth_r == IW'(1)) begin
            state_nxt = ST_DONE;
          end else begin
            visited_nxt[prev_city] = 1'b0;
            depth_nxt              = top_idx;
          end
        end else if (visited_r[cand_city]) begin
          cand_we = 1'b1;
        end else begin
          // Fetch the edge from the city on top to the candidate.
          cand_we   = 1'b1;
          rd_en     = 1'b1;
          city_nxt  = cand_city;
          state_nxt = ST_EVAL;
        end
      end

      ST_EVAL: begin
        if (last_level) begin
          // Every city placed: fetch the edge that returns to city zero.
          hold_nxt  = sum;
          rd_en     = 1'b1;
          rd_row    = city_r;
          rd_col    = '0;
          state_nxt = ST_CLOSE;
        end else if (BW'(sum) >= best_r) begin
          // This branch cannot beat the best tour found so far.
          state_nxt = ST_SCAN;
        end else begin
          push_we              = 1'b1;
          visited_nxt[city_r]  = 1'b1;
          cand_we              = 1'b1;
          cand_idx             = depth_r + 1'b1;
          cand_val             = CW'(1);
          depth_nxt            = depth_r + 1'b1;
          state_nxt            = ST_SCAN;
        end
      end

      ST_CLOSE: begin
        if (BW'(sum) < best_r) begin
          best_nxt = BW'(sum);
        end
        state_nxt = ST_SCAN;
      end

      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      depth_r   <= '0;
      visited_r <= '0;
      no_tour_r <= 1'b0;
      best_r    <= '1;
    end else begin
      state_r   <= state_nxt;
      depth_r   <= depth_nxt;
      visited_r <= visited_nxt;
      no_tour_r <= no_tour_nxt;
      best_r    <= best_nxt;
    end
  end

  // Working registers and level stacks.
  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    hold_r <= hold_nxt;
    city_r <= city_nxt;
    if (cand_we) begin
      cand_r[cand_idx] <= cand_val;
    end
    if (push_we) begin
      path_r[push_idx] <= push_city;
      cost_r[push_idx] <= push_cost;
    end
  end

  assign idle          = (state_r == ST_IDLE);
  assign res_valid     = (state_r == ST_DONE);
  assign res.no_tour   = no_tour_r;
  assign res.best_cost = no_tour_r ? '0 : BEST_W'(best_r);

endmodule

// ===== dv/tb_tsp_exhaustive_search.sv =====
// Self-checking testbench for the exhaustive travelling-salesman search block.
`timescale 1ns / 1ps

module tb_tsp_exhaustive_search;
  import tsp_pkg::*;

  localparam int MAXC = MAX_CITIES_DEF;
  // Longest silent stretch of a correct run is a seven-city search without
  // pruning; the limit allows several times that.
  localparam int QUIET_LIMIT = 200000;
  // Cycles allowed after the last transfer for a load to settle in the block.
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 30;
  localparam int PHASE_ITEMS = 34;

  localparam logic [APB_AW-1:0] ADDR_CITY_COUNT = {REG_CITY_COUNT, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_UNUSED = {~REG_CITY_COUNT, 2'b00};

  typedef struct packed {
    logic                 req_type;
    logic [CITY_W-1:0]    from_city;
    logic [CITY_W-1:0]    to_city;
    logic [COST_IN_W-1:0] edge_cost;
  } req_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  tsp_in_if  in_ch ();
  tsp_out_if out_ch ();

  tsp_exhaustive_search i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Requests waiting to be driven and tour results still to arrive.
  req_t     pending_reqs[$];
  tsp_res_t tour_results[$];

  // Shadow of the block's cost store and city count register.
  logic [COST_IN_W-1:0] cost_table [MAXC][MAXC];
  logic [CCOUNT_W-1:0]  city_count_q = CITY_COUNT_RST;

  // Idling controls, set per phase.
  int snd_max = 0;
  int rcv_max = 0;
  int send_gap = 0;
  int hold_cnt = 0;
  bit sending = 1'b0;
  bit in_took = 1'b0;
  bit out_took = 1'b0;

  int fails = 0;
  int quiet = 0;
  int load_count = 0;
  int run_count = 0;
  int no_tour_count = 0;
  int widest_run = 0;

  // Least closed-tour cost from city zero, by depth-first branch and bound.
  function automatic logic [BEST_W-1:0] least_tour_cost(input int n);
    int unsigned path [MAXC];
    int unsigned acc [MAXC];
    int          cand [MAXC];
    bit          seen [MAXC];
    int          d;
    int          k;
    int unsigned step;
    int unsigned best;
    best = 32'h001F_FFFF;
    for (int i = 0; i < MAXC; i++) seen[i] = 1'b0;
    d = 0;
    path[0] = 0;
    acc[0] = 0;
    cand[0] = 1;
    seen[0] = 1'b1;
    while (d >= 0) begin
      if (d == n - 1) begin
        // Every city placed: close the tour back to city zero.
        step = acc[d] + cost_table[path[d]][0];
        if (step < best) best = step;
        seen[path[d]] = 1'b0;
        d--;
      end else if (cand[d] >= n) begin
        seen[path[d]] = 1'b0;
        d--;
      end else begin
        k = cand[d];
        cand[d]++;
        if (!seen[k]) begin
          step = acc[d] + cost_table[path[d]][k];
          // Costs are never negative, so a partial cost at or above the best cannot win.
          if (step < best) begin
            d++;
            path[d] = k;
            acc[d] = step;
            cand[d] = 1;
            seen[k] = 1'b1;
          end
        end
      end
    end
    return best[BEST_W-1:0];
  endfunction

  function automatic logic [COST_IN_W-1:0] rand_cost();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return COST_IN_W'($urandom_range(0, 15));
      default: return COST_IN_W'($urandom());
    endcase
  endfunction

  function automatic int rand_idle();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 14;
    endcase
  endfunction

  task automatic queue_load(input int from_c, input int to_c, input logic [COST_IN_W-1:0] c);
    req_t r;
    r.req_type = REQ_LOAD;
    r.from_city = CITY_W'(from_c);
    r.to_city = CITY_W'(to_c);
    r.edge_cost = c;
    pending_reqs.push_back(r);
  endtask

  task automatic queue_run();
    req_t r;
    r.req_type = REQ_RUN;
    r.from_city = CITY_W'($urandom());
    r.to_city = CITY_W'($urandom());
    r.edge_cost = COST_IN_W'($urandom());
    pending_reqs.push_back(r);
  endtask

  // Wait until every request has been sent and every result has come back.
  task automatic drain();
    @(posedge clk);
    while (pending_reqs.size() != 0 || sending || tour_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_CITY_COUNT) city_count_q = data[CCOUNT_W-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic cfg_read_check();
    logic [APB_DW-1:0] rd;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_CITY_COUNT;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd[CCOUNT_W-1:0] !== city_count_q) begin
      $error("city_count read mismatch: expected %0d, actual %0d", city_count_q,
             rd[CCOUNT_W-1:0]);
      fails++;
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Request driver: inputs change on the falling edge.
  always @(negedge clk) begin : drive_requests
    req_t nxt;
    if (in_took) sending = 1'b0;
    if (!sending) begin
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_reqs.size() > 0) begin
        nxt = pending_reqs.pop_front();
        in_ch.req_type <= nxt.req_type;
        in_ch.from_city <= nxt.from_city;
        in_ch.to_city <= nxt.to_city;
        in_ch.edge_cost <= nxt.edge_cost;
        sending = 1'b1;
        send_gap = $urandom_range(0, snd_max);
      end
    end
    in_ch.valid <= sending;
  end

  // Result receiver: each result is held off for a drawn number of cycles.
  always @(negedge clk) begin : accept_results
    if (out_took) begin
      hold_cnt = $urandom_range(0, rcv_max);
    end else if (hold_cnt > 0 && out_ch.valid) begin
      hold_cnt--;
    end
    out_ch.ready <= (hold_cnt == 0);
  end

  // Monitor: predicts on each request transfer and checks each result transfer.
  always @(posedge clk) begin : watch_channels
    bit       in_x;
    bit       out_x;
    int       n;
    tsp_res_t r;
    tsp_res_t want;
    in_x = rst_n && in_ch.valid && in_ch.ready;
    out_x = rst_n && out_ch.valid && out_ch.ready;
    in_took <= in_x;
    out_took <= out_x;

    if (in_x) begin
      if (in_ch.req_type == REQ_LOAD) begin
        cost_table[in_ch.from_city][in_ch.to_city] = in_ch.edge_cost;
        load_count++;
      end else begin
        // A count above the maximum saturates; fewer than two cities means no tour.
        n = (city_count_q > MAXC) ? MAXC : city_count_q;
        r.no_tour = (n < 2);
        r.best_cost = (n < 2) ? '0 : least_tour_cost(n);
        tour_results.push_back(r);
        run_count++;
        if (n < 2) no_tour_count++;
        if (n > widest_run) widest_run = n;
      end
    end

    if (out_x) begin
      if (tour_results.size() == 0) begin
        $error("result transfer with no search outstanding: best_cost %0d no_tour %0d",
               out_ch.best_cost, out_ch.no_tour);
        fails++;
      end else begin
        want = tour_results.pop_front();
        if (out_ch.best_cost !== want.best_cost) begin
          $error("best_cost mismatch: expected %0d, actual %0d", want.best_cost,
                 out_ch.best_cost);
          fails++;
        end
        if (out_ch.no_tour !== want.no_tour) begin
          $error("no_tour mismatch: expected %0d, actual %0d", want.no_tour, out_ch.no_tour);
          fails++;
        end
      end
    end

    // Watchdog on cycles without any transfer.
    if (!rst_n || in_x || out_x) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin : stimulus
    int n;
    int runs_left;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_LOAD;
    in_ch.from_city = '0;
    in_ch.to_city = '0;
    in_ch.edge_cost = '0;
    out_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Check the reset count, then fill the whole cost store so no run reads an unset entry.
    cfg_read_check();
    cfg_write(ADDR_CITY_COUNT, MAXC);
    for (int i = 0; i < MAXC; i++) begin
      for (int j = 0; j < MAXC; j++) queue_load(i, j, rand_cost());
    end
    drain();

    // Directed cases: smallest tours, too few cities, cost extremes, register masking.
    snd_max = 14;
    rcv_max = 14;
    cfg_write(ADDR_CITY_COUNT, 2);
    queue_run();
    drain();
    cfg_write(ADDR_CITY_COUNT, 1);
    queue_run();
    drain();
    cfg_write(ADDR_CITY_COUNT, 0);
    cfg_read_check();
    queue_run();
    drain();
    cfg_write(ADDR_CITY_COUNT, 32'hFFFF_FFE3);
    cfg_read_check();
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) queue_load(i, j, '1);
    end
    queue_run();
    queue_load(0, 1, '0);
    queue_load(1, 2, '0);
    queue_load(2, 0, '0);
    queue_load(MAXC - 1, MAXC - 1, '1);
    queue_run();
    drain();
    // A write to an unused register must leave the city count alone.
    cfg_write(ADDR_UNUSED, 5);
    cfg_read_check();
    queue_run();
    drain();

    // Random phases with small city counts, varied idling and, in every fourth phase, a wait for results midway.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 5) n = 7;
      else if ($urandom_range(0, 7) == 0) n = $urandom_range(0, 1);
      else n = $urandom_range(2, 6);
      snd_max = rand_idle();
      rcv_max = rand_idle();
      if ($urandom_range(0, 3) == 0) cfg_write(ADDR_CITY_COUNT, ($urandom() & 32'hFFFF_FFE0) | n);
      else cfg_write(ADDR_CITY_COUNT, n);
      if (ph % 5 == 0) cfg_read_check();
      runs_left = (n >= 7) ? 2 : (n == 6) ? 4 : 12;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph % 4 == 1 && k == PHASE_ITEMS / 2) drain();
        if (runs_left > 0 && $urandom_range(0, 2) == 0) begin
          queue_run();
          runs_left--;
        end else if (n >= 2 && $urandom_range(0, 3) != 0) begin
          queue_load($urandom_range(0, n - 1), $urandom_range(0, n - 1), rand_cost());
        end else begin
          queue_load($urandom_range(0, MAXC - 1), $urandom_range(0, MAXC - 1), rand_cost());
        end
      end
      drain();
    end

    // Full-size search on a ring of cheap edges, so pruning keeps it short,
    // then the same with a count above the maximum.
    snd_max = 0;
    rcv_max = 14;
    cfg_write(ADDR_CITY_COUNT, MAXC);
    for (int i = 0; i < MAXC; i++) begin
      for (int j = 0; j < MAXC; j++) begin
        if (j == (i + 1) % MAXC || i == (j + 1) % MAXC) begin
          queue_load(i, j, COST_IN_W'($urandom_range(0, 3)));
        end else begin
          queue_load(i, j, '1);
        end
      end
    end
    queue_run();
    drain();
    cfg_write(ADDR_CITY_COUNT, 31);
    cfg_read_check();
    queue_run();
    drain();

    if (tour_results.size() != 0) begin
      $error("%0d tour results never arrived", tour_results.size());
      fails++;
    end
    $display("Covered %0d cost loads and %0d searches, %0d of them without a tour.",
             load_count, run_count, no_tour_count);
    $display("City counts from zero up to saturation were used; widest search: %0d cities.",
             widest_run);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
